/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL. They compile away in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLY(name, clk, rst, ante, cons)
`define ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

/* rtl/bnfa_pkg.sv */
`timescale 1ns / 1ps

package bnfa_pkg;

   // Map geometry.
   localparam int MAP_BYTES  = 512;
   localparam int IDX_W      = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
   localparam int UNIT_COUNT = MAP_BYTES * 8;

   // Field widths and constants.
   localparam int          FIELD_W     = 13;
   localparam int          CSR_DATA_W  = 32;
   localparam int          CSR_ADDR_W  = 3;
   localparam logic [12:0] COUNT_MAX   = 13'h1FFF;
   localparam logic [12:0] COUNT_RESET = 13'd4096;
   localparam logic [7:0]  BYTE_FULL   = 8'hFF;
   localparam logic [7:0]  TOP_BIT     = 8'h80;

   // Register indexes (selected by paddr[2]).
   localparam logic REG_INITIAL_FREE = 1'b0;
   localparam logic REG_NUMBER_BASE  = 1'b1;

   typedef enum logic [1:0] {
      CMD_ALLOC  = 2'd0,
      CMD_FREE   = 2'd1,
      CMD_FORMAT = 2'd2,
      CMD_NOP    = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NONE_FREE = 2'd1,
      ST_RANGE     = 2'd2,
      ST_ALREADY   = 2'd3
   } status_type;

   // Position of the first clear bit counted from the MSB.
   function automatic logic [2:0] first_clear(input logic [7:0] value);
      logic [2:0] pos;
      logic       found;
      pos   = '0;
      found = 1'b0;
      for (int i = 0; i < 8; i++) begin
         if (!found && !value[7 - i]) begin
            pos   = 3'(i);
            found = 1'b1;
         end
      end
      return pos;
   endfunction

endpackage

/* rtl/bitmap_next_fit_allocator_unit.sv */
`timescale 1ns / 1ps

// Next-fit bitmap allocator over 4096 units held in a 512-byte map memory. A
// transaction is taken when start is high and busy is low; its single result
// appears on the rsp_ ports for exactly one cycle with rsp_valid, and the
// receiver cannot stall it. Timing is set by the map memory, which has one
// registered read port and one write port and is visited one byte a cycle:
// a no-operation, a rejected free and an allocate with no free units answer
// from idle; a free reads its byte, then writes it back; an allocate scans
// from the last granted byte to a clear bit or over every byte; a format
// answers at once, then stays busy for a clearing pass, which also runs
// after reset; no transaction is accepted during it. Configuration writes
// are taken at any time but should only be issued while the block is idle.
module bitmap_next_fit_allocator_unit
   import bnfa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Request channel
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_command,
   input  logic [FIELD_W-1:0]    req_unit_number,
   // Result channel
   output logic                  rsp_valid,
   output logic [FIELD_W-1:0]    rsp_granted_unit,
   output logic [1:0]            rsp_status,
   output logic [FIELD_W-1:0]    rsp_free_left,
   // Register port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

`include "assert_macros.svh"

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_CLEAR = 4'b0010,
      S_SCAN  = 4'b0100,
      S_FREE  = 4'b1000
   } state_type;

   state_type           state_ff, state_in;
   logic [IDX_W-1:0]    pos_ff, pos_in;
   logic [IDX_W-1:0]    laps_ff, laps_in;
   logic [2:0]          bit_ff, bit_in;
   logic [IDX_W-1:0]    search_ff, search_in;
   logic [FIELD_W-1:0]  free_count_ff, free_count_in;
   logic [FIELD_W-1:0]  initial_free_ff;
   logic                number_base_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [FIELD_W-1:0]  rsp_granted_ff, rsp_granted_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [FIELD_W-1:0]  rsp_free_left_ff;

   logic [7:0]          map_mem [MAP_BYTES];
   logic [7:0]          rd_data_ff;
   logic                mem_we;
   logic [7:0]          mem_wdata;

   logic                accept;
   logic                csr_write;
   logic [IDX_W-1:0]    pos_next;
   logic [IDX_W-1:0]    start_pos;
   logic [31:0]         unit_ext;
   logic [31:0]         grant_sum;
   logic [2:0]          scan_bit;
   logic [7:0]          scan_mask;
   logic [7:0]          free_mask;

   assign accept    = start && (state_ff == S_IDLE);
   assign csr_write = psel && penable && pwrite;

   // Register port: always ready, one register per word.
   assign pready = 1'b1;
   always_comb begin
      case (paddr[2])
         REG_INITIAL_FREE: prdata = CSR_DATA_W'(initial_free_ff);
         REG_NUMBER_BASE:  prdata = CSR_DATA_W'(number_base_ff);
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         initial_free_ff <= COUNT_RESET;
         number_base_ff  <= 1'b0;
      end else if (csr_write) begin
         case (paddr[2])
            REG_INITIAL_FREE: initial_free_ff <= pwdata[FIELD_W-1:0];
            REG_NUMBER_BASE:  number_base_ff  <= pwdata[0];
            default:          initial_free_ff <= initial_free_ff;
         endcase
      end
   end

   // Shared datapath helpers.
   assign pos_next  = (pos_ff == IDX_W'(MAP_BYTES - 1)) ? '0 : pos_ff + IDX_W'(1);
   assign start_pos = (int'(search_ff) < MAP_BYTES) ? search_ff : '0;
   assign unit_ext  = 32'(req_unit_number) - 32'(number_base_ff);
   assign scan_bit  = first_clear(rd_data_ff);
   assign scan_mask = TOP_BIT >> scan_bit;
   assign free_mask = TOP_BIT >> bit_ff;
   assign grant_sum = 32'({pos_ff, scan_bit}) + 32'(number_base_ff);

   // Sequencer: one map byte is examined or written per cycle.
   always_comb begin
      state_in       = state_ff;
      pos_in         = pos_ff;
      laps_in        = laps_ff;
      bit_in         = bit_ff;
      search_in      = search_ff;
      free_count_in  = free_count_ff;
      rsp_valid_in   = 1'b0;
      rsp_granted_in = '0;
      rsp_status_in  = ST_OK;
      mem_we         = 1'b0;
      mem_wdata      = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (command_type'(req_command))
                  CMD_ALLOC: begin
                     if (free_count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_NONE_FREE;
                     end else begin
                        pos_in   = start_pos;
                        laps_in  = '0;
                        state_in = S_SCAN;
                     end
                  end
                  CMD_FREE: begin
                     if ((32'(req_unit_number) < 32'(number_base_ff)) ||
                         (unit_ext >= 32'(UNIT_COUNT))) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_RANGE;
                     end else begin
                        pos_in   = unit_ext[IDX_W+2:3];
                        bit_in   = unit_ext[2:0];
                        state_in = S_FREE;
                     end
                  end
                  CMD_FORMAT: begin
                     free_count_in = initial_free_ff;
                     search_in     = '0;
                     pos_in        = '0;
                     state_in      = S_CLEAR;
                     rsp_valid_in  = 1'b1;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (rd_data_ff != BYTE_FULL) begin
               // Clear bit found: claim it and report the unit.
               mem_we         = 1'b1;
               mem_wdata      = rd_data_ff | scan_mask;
               search_in      = pos_ff;
               free_count_in  = free_count_ff - FIELD_W'(1);
               rsp_valid_in   = 1'b1;
               rsp_granted_in = grant_sum[FIELD_W-1:0];
               state_in       = S_IDLE;
            end else if (laps_ff == IDX_W'(MAP_BYTES - 1)) begin
               // A whole lap of full bytes despite a nonzero count.
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_NONE_FREE;
               state_in      = S_IDLE;
            end else begin
               laps_in = laps_ff + IDX_W'(1);
               pos_in  = pos_next;
            end
         end
         S_FREE: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
            if ((rd_data_ff & free_mask) == '0) begin
               rsp_status_in = ST_ALREADY;
            end else begin
               mem_we    = 1'b1;
               mem_wdata = rd_data_ff & ~free_mask;
               if (free_count_ff != COUNT_MAX) begin
                  free_count_in = free_count_ff + FIELD_W'(1);
               end
            end
         end
         S_CLEAR: begin
            // Clearing pass, one byte a cycle.
            mem_we = 1'b1;
            if (pos_ff == IDX_W'(MAP_BYTES - 1)) begin
               pos_in   = '0;
               state_in = S_IDLE;
            end else begin
               pos_in = pos_next;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         pos_ff        <= '0;
         search_ff     <= '0;
         free_count_ff <= COUNT_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pos_ff        <= pos_in;
         search_ff     <= search_in;
         free_count_ff <= free_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      laps_ff          <= laps_in;
      bit_ff           <= bit_in;
      rsp_granted_ff   <= rsp_granted_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_free_left_ff <= free_count_in;
   end

   // Map memory: one write port, one registered read port that follows the
   // byte the sequencer will look at next.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[pos_ff] <= mem_wdata;
      end
      rd_data_ff <= map_mem[pos_in];
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_granted_unit = rsp_granted_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_free_left    = rsp_free_left_ff;

   // Only a successful allocation reports a nonzero unit.
   `ASSERT_IMPLY(a_grant_only_ok, clock, reset, rsp_valid && |rsp_granted_unit, rsp_status == ST_OK)
   // Every accepted transaction answers at once or keeps the block busy.
   `ASSERT_NEXT(a_accept_progress, clock, reset, start && !busy, rsp_valid || busy)
   // A rejected request leaves the free count untouched.
   `ASSERT_IMPLY(a_reject_hold, clock, reset, rsp_valid && rsp_status != ST_OK, $stable(free_count_ff))
   // The scan never runs more than one lap.
   `ASSERT_IMPLY(a_scan_lap_bound, clock, reset, state_ff == S_SCAN, int'(laps_ff) < MAP_BYTES)

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;
   import bnfa_pkg::*;

   localparam int STALL_LIMIT = 4000;
   localparam int TAIL_CYCLES = 600;

   // One result as the block reports it.
   typedef struct packed {
      logic [FIELD_W-1:0] granted;
      status_type         status;
      logic [FIELD_W-1:0] free_left;
   } alloc_outcome_type;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [1:0]            req_command;
   logic [FIELD_W-1:0]    req_unit_number;
   logic                  rsp_valid;
   logic [FIELD_W-1:0]    rsp_granted_unit;
   logic [1:0]            rsp_status;
   logic [FIELD_W-1:0]    rsp_free_left;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // Allocator state as the testbench expects it to be.
   logic [7:0]         unit_map [MAP_BYTES];
   int                 next_fit_byte;
   logic [FIELD_W-1:0] units_free;
   logic [FIELD_W-1:0] format_count;
   logic               unit_offset;

   alloc_outcome_type outcomes_due[$];
   int                mismatches;
   int                stall_cycles;
   bit                idle_enabled;

   bitmap_next_fit_allocator_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_unit_number  (req_unit_number),
      .rsp_valid        (rsp_valid),
      .rsp_granted_unit (rsp_granted_unit),
      .rsp_status       (rsp_status),
      .rsp_free_left    (rsp_free_left),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Applies one command to the expected state and returns the result it causes.
   function automatic alloc_outcome_type allocator_outcome(command_type cmd,
                                                           logic [FIELD_W-1:0] number);
      alloc_outcome_type outcome;
      int                pos;
      int                laps;
      int                bit_idx;
      int                unit;
      outcome.granted = '0;
      outcome.status  = ST_OK;
      case (cmd)
         CMD_ALLOC: begin
            if (units_free == 0) begin
               outcome.status = ST_NONE_FREE;
            end else begin
               // Skip full bytes from the byte of the last grant, wrapping once.
               pos  = next_fit_byte;
               laps = 0;
               while (laps < MAP_BYTES && unit_map[pos] == BYTE_FULL) begin
                  pos = (pos + 1 >= MAP_BYTES) ? 0 : pos + 1;
                  laps++;
               end
               if (laps >= MAP_BYTES) begin
                  outcome.status = ST_NONE_FREE;
               end else begin
                  bit_idx = 0;
                  while (unit_map[pos][7 - bit_idx]) bit_idx++;
                  unit_map[pos][7 - bit_idx] = 1'b1;
                  next_fit_byte   = pos;
                  units_free      = units_free - 1'b1;
                  outcome.granted = FIELD_W'(pos * 8 + bit_idx + int'(unit_offset));
               end
            end
         end
         CMD_FREE: begin
            unit = int'(number) - int'(unit_offset);
            if (unit < 0 || unit >= UNIT_COUNT) begin
               outcome.status = ST_RANGE;
            end else if (!unit_map[unit / 8][7 - unit % 8]) begin
               outcome.status = ST_ALREADY;
            end else begin
               unit_map[unit / 8][7 - unit % 8] = 1'b0;
               if (units_free != COUNT_MAX) units_free = units_free + 1'b1;
            end
         end
         CMD_FORMAT: begin
            foreach (unit_map[i]) unit_map[i] = '0;
            units_free    = format_count;
            next_fit_byte = 0;
         end
         default: ;
      endcase
      outcome.free_left = units_free;
      return outcome;
   endfunction

   // Number of a unit currently in use, or a random number if the map is empty.
   function automatic logic [FIELD_W-1:0] held_unit_number();
      int origin;
      int u;
      origin = $urandom_range(0, UNIT_COUNT - 1);
      for (int k = 0; k < UNIT_COUNT; k++) begin
         u = (origin + k) % UNIT_COUNT;
         if (unit_map[u / 8][7 - u % 8]) return FIELD_W'(u + int'(unit_offset));
      end
      return FIELD_W'(origin + int'(unit_offset));
   endfunction

   task automatic compare_field(string name, int expected, int actual);
      if (expected != actual) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, expected, actual);
         mismatches++;
      end
   endtask

   // Each result is matched against the oldest outstanding expectation.
   always @(posedge clock) begin : result_check
      alloc_outcome_type due;
      if (!reset && rsp_valid) begin
         if (outcomes_due.size() == 0) begin
            $display("%0t: result with no transaction outstanding, granted %0d status %0d",
                     $time, rsp_granted_unit, rsp_status);
            mismatches++;
         end else begin
            due = outcomes_due.pop_front();
            compare_field("granted_unit", int'(due.granted), int'(rsp_granted_unit));
            compare_field("status", int'(due.status), int'(rsp_status));
            compare_field("free_left", int'(due.free_left), int'(rsp_free_left));
         end
      end
   end

   // Ends the run if neither a transaction nor a result moves for too long.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Sends one transaction, with an occasional idle burst first. Start stays high
   // on return so that a following transaction can go out without a gap.
   task automatic send_item(command_type cmd, logic [FIELD_W-1:0] number);
      int gap;
      if (idle_enabled && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 13);
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_command     <= cmd;
      req_unit_number <= number;
      start           <= 1'b1;
      do @(posedge clock); while (busy);
      outcomes_due.push_back(allocator_outcome(cmd, number));
      @(negedge clock);
   endtask

   // Stops sending until every expected result has come back.
   task automatic await_results();
      start <= 1'b0;
      do @(posedge clock); while (outcomes_due.size() != 0);
      @(negedge clock);
   endtask

   // As above, and also waits for any clearing pass to finish.
   task automatic settle();
      start <= 1'b0;
      do @(posedge clock); while (outcomes_due.size() != 0 || busy);
      @(negedge clock);
   endtask

   task automatic apb_access(logic is_write, logic index, logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= is_write;
      paddr   <= {index, 2'b00};
      pwdata  <= wdata;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Writes a register, records it for prediction and reads it back.
   task automatic set_register(logic index, logic [FIELD_W-1:0] value);
      logic [CSR_DATA_W-1:0] readback;
      apb_access(1'b1, index, CSR_DATA_W'(value), readback);
      if (index == REG_INITIAL_FREE) begin
         format_count = value;
         apb_access(1'b0, index, '0, readback);
         compare_field("initial_free readback", int'(value), int'(readback[FIELD_W-1:0]));
      end else begin
         unit_offset = value[0];
         apb_access(1'b0, index, '0, readback);
         compare_field("number_base readback", int'(value[0]), int'(readback[0]));
      end
   endtask

   task automatic apply_settings(logic [FIELD_W-1:0] initial_free, logic base);
      settle();
      set_register(REG_INITIAL_FREE, initial_free);
      set_register(REG_NUMBER_BASE, FIELD_W'(base));
   endtask

   // Grants, frees, double frees, out-of-range frees and format with blocks.
   task automatic test_basic_commands();
      send_item(CMD_NOP, 13'h1FFF);
      send_item(CMD_ALLOC, 13'h1FFF);
      send_item(CMD_ALLOC, '0);
      send_item(CMD_ALLOC, '0);
      send_item(CMD_FREE, 13'd1);
      send_item(CMD_FREE, 13'd1);
      send_item(CMD_FREE, 13'd4096);
      send_item(CMD_FREE, 13'h1FFF);
      send_item(CMD_ALLOC, '0);
      send_item(CMD_FORMAT, 13'h0AAA);
      send_item(CMD_ALLOC, 13'h1555);
   endtask

   // Inode numbering: numbers start at one and the top unit reads as 4096.
   task automatic test_unit_offset();
      apply_settings(13'd4096, 1'b1);
      send_item(CMD_FORMAT, '0);
      send_item(CMD_ALLOC, '0);
      send_item(CMD_FREE, 13'd0);
      send_item(CMD_FREE, 13'd4096);
      send_item(CMD_FREE, 13'd4097);
      send_item(CMD_FREE, 13'd1);
   endtask

   // Allocation with no free count left, and the count at the top of its range.
   task automatic test_count_exhaustion();
      apply_settings(13'd0, 1'b0);
      send_item(CMD_FORMAT, '0);
      send_item(CMD_ALLOC, '0);
      apply_settings(13'd2, 1'b0);
      send_item(CMD_FORMAT, '0);
      repeat (3) send_item(CMD_ALLOC, '0);
      apply_settings(COUNT_MAX, 1'b0);
      send_item(CMD_FORMAT, '0);
      send_item(CMD_ALLOC, '0);
      send_item(CMD_FREE, 13'd0);
   endtask

   // Fills the first three bytes, then checks that the search skips a full
   // byte and keeps moving forward past units freed behind it.
   task automatic test_next_fit_order();
      apply_settings(COUNT_MAX, 1'b1);
      send_item(CMD_FORMAT, '0);
      repeat (24) send_item(CMD_ALLOC, FIELD_W'($urandom));
      send_item(CMD_ALLOC, '0);
      send_item(CMD_FREE, 13'd11);
      send_item(CMD_ALLOC, '0);
      send_item(CMD_FREE, 13'd4096);
      send_item(CMD_FREE, 13'd4096);
      send_item(CMD_ALLOC, '0);
      send_item(CMD_FREE, 13'd1);
      send_item(CMD_ALLOC, '0);
   endtask

   // Mostly allocations and frees of units in use, with noise mixed in.
   task automatic test_random_traffic(logic [FIELD_W-1:0] initial_free, logic base,
                                      int count, bit hold_midway);
      int pick;
      apply_settings(initial_free, base);
      send_item(CMD_FORMAT, FIELD_W'($urandom));
      for (int n = 0; n < count; n++) begin
         if (hold_midway && n == count / 2) await_results();
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            send_item(CMD_ALLOC, FIELD_W'($urandom));
         end else if (pick < 80) begin
            send_item(CMD_FREE, held_unit_number());
         end else if (pick < 88) begin
            send_item(CMD_FREE, FIELD_W'($urandom));
         end else if (pick < 93) begin
            case ($urandom_range(0, 2))
               0: send_item(CMD_FREE, FIELD_W'(int'(base) - 1));
               1: send_item(CMD_FREE, FIELD_W'(UNIT_COUNT - 1 + int'(base)));
               default: send_item(CMD_FREE, FIELD_W'(UNIT_COUNT + int'(base)));
            endcase
         end else if (pick < 98) begin
            send_item(CMD_NOP, FIELD_W'($urandom));
         end else begin
            send_item(CMD_FORMAT, FIELD_W'($urandom));
         end
      end
   endtask

   initial begin
      reset           <= 1'b1;
      start           <= 1'b0;
      req_command     <= CMD_NOP;
      req_unit_number <= '0;
      psel            <= 1'b0;
      penable         <= 1'b0;
      pwrite          <= 1'b0;
      paddr           <= '0;
      pwdata          <= '0;
      mismatches      = 0;
      stall_cycles    = 0;
      idle_enabled    = 1'b1;
      foreach (unit_map[i]) unit_map[i] = '0;
      next_fit_byte = 0;
      units_free    = COUNT_RESET;
      format_count  = COUNT_RESET;
      unit_offset   = 1'b0;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      settle();

      test_basic_commands();
      test_unit_offset();
      test_count_exhaustion();
      test_next_fit_order();
      test_random_traffic(COUNT_RESET, 1'b0, 320, 1'b0);
      test_random_traffic(COUNT_MAX, 1'b1, 320, 1'b0);
      test_random_traffic(13'd1, 1'b0, 320, 1'b1);
      test_random_traffic(FIELD_W'($urandom), 1'b1, 320, 1'b0);
      test_random_traffic(13'd0, 1'b0, 320, 1'b0);
      idle_enabled = 1'b0;
      test_random_traffic(COUNT_RESET, 1'($urandom), 320, 1'b0);

      // Let the last results and any clearing pass finish.
      settle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
